### hdl/utd_pkg.sv
// Shared constants and types for the Unicode text decoder.
// No dependencies; used by the decoder top level and its port checker.
package utd_pkg;

    // Encoding mode codes held in the configuration register
    localparam logic [2:0] MODE_UTF8    = 3'd0;
    localparam logic [2:0] MODE_UTF16LE = 3'd1;
    localparam logic [2:0] MODE_UTF16BE = 3'd2;
    localparam logic [2:0] MODE_UTF32LE = 3'd3;
    localparam logic [2:0] MODE_UTF32BE = 3'd4;
    localparam logic [2:0] MODE_ASCII   = 3'd5;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;
    localparam int GATH_W  = 24;
    localparam int OUT_W   = CP_W + CNT_W;

    // Status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // Code point limits
    localparam logic [31:0] CP_LIMIT    = 32'h0011_0000;
    localparam logic [15:0] SURR_HI_LO  = 16'hD800;
    localparam logic [15:0] SURR_LO_LO  = 16'hDC00;
    localparam logic [15:0] SURR_END    = 16'hE000;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;

    // Swap the two bytes of a 16-bit unit for little-endian input
    function automatic logic [15:0] unit16(input logic [15:0] pair, input logic little);
        logic [15:0] res;
        res = little ? {pair[7:0], pair[15:8]} : pair;
        return res;
    endfunction

endpackage

### hdl/unicode_text_decoder.sv
// Unicode text decoder: one byte per word in, one code point or error per character out.
// Depends on utd_pkg for mode codes, widths and limits.
//
// The result of an accepted byte is registered in the output register.
// Throughput: one byte per cycle; the single output register limits it only while
// the result side stalls. Reset clears the mode to UTF-8, all decode state,
// the error latch and the output valid.
module unicode_text_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [utd_pkg::MODE_W-1:0] cfg_wr_data,
    // byte input
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
    input  logic                      s_axis_tlast,   // end_of_text
    // result output
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // [20:0] code_point, [23:21] bytes_used
    output logic                      m_axis_tuser    // [0] status
);

    logic [utd_pkg::MODE_W-1:0]  mode_reg;
    logic [utd_pkg::CNT_W-1:0]   seen_reg, seen_next;
    logic [utd_pkg::CNT_W-1:0]   exp_reg, exp_next;
    logic [utd_pkg::GATH_W-1:0]  gath_reg, gath_next;
    logic                        err_lat_reg, err_lat_next;

    logic                        out_valid_reg;
    logic [utd_pkg::CP_W-1:0]    out_cp_reg;
    logic [utd_pkg::CNT_W-1:0]   out_used_reg;
    logic                        out_stat_reg;

    logic                        accept;
    logic [7:0]                  b;
    logic [31:0]                 g;
    logic [utd_pkg::CNT_W-1:0]   seen_n;
    logic                        done, err, emit;
    logic [utd_pkg::CP_W-1:0]    cp;
    logic [15:0]                 u1, u2;
    logic [31:0]                 v32;
    logic                        little;

    // Take a new byte whenever the output register is free or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign b      = s_axis_tdata;
    assign g      = {gath_reg, b};
    assign seen_n = seen_reg + 3'd1;

    // Decode the byte against the pending character
    always_comb begin
        done   = 1'b0;
        err    = 1'b0;
        cp     = '0;
        exp_next = exp_reg;
        little = (mode_reg == utd_pkg::MODE_UTF16LE);
        u1     = '0;
        u2     = '0;
        v32    = g;
        unique case (mode_reg)
            utd_pkg::MODE_UTF8: begin
                if (seen_n == 3'd1) begin
                    if (b[7] == 1'b0) begin
                        done = 1'b1;
                        cp   = {13'd0, b};
                    end else if (b[7:5] == 3'b110) begin
                        exp_next = 3'd2;
                    end else if (b[7:4] == 4'b1110) begin
                        exp_next = 3'd3;
                    end else if (b[7:3] == 5'b11110) begin
                        exp_next = 3'd4;
                    end else begin
                        err = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    err = 1'b1;
                end else if (seen_n >= exp_reg) begin
                    done = 1'b1;
                    if (exp_reg == 3'd2) begin
                        cp = {10'd0, g[12:8], g[5:0]};
                    end else if (exp_reg == 3'd3) begin
                        cp = {5'd0, g[19:16], g[13:8], g[5:0]};
                    end else begin
                        cp = {g[26:24], g[21:16], g[13:8], g[5:0]};
                    end
                end
            end
            utd_pkg::MODE_UTF16LE, utd_pkg::MODE_UTF16BE: begin
                if (seen_n == 3'd1) begin
                    exp_next = 3'd2;
                end else if (seen_n == 3'd2) begin
                    u1 = utd_pkg::unit16(g[15:0], little);
                    if (u1 >= utd_pkg::SURR_HI_LO && u1 < utd_pkg::SURR_LO_LO) begin
                        exp_next = 3'd4;
                    end else if (u1 >= utd_pkg::SURR_LO_LO && u1 < utd_pkg::SURR_END) begin
                        err = 1'b1;
                    end else begin
                        done = 1'b1;
                        cp   = {5'd0, u1};
                    end
                end else if (seen_n >= 3'd4) begin
                    u1 = utd_pkg::unit16(g[31:16], little);
                    u2 = utd_pkg::unit16(g[15:0], little);
                    if (u1 < utd_pkg::SURR_HI_LO || u1 >= utd_pkg::SURR_LO_LO
                        || u2 < utd_pkg::SURR_LO_LO || u2 >= utd_pkg::SURR_END) begin
                        err = 1'b1;
                    end else begin
                        done = 1'b1;
                        cp   = {1'b0, u1[9:0], u2[9:0]} + utd_pkg::SUPP_BASE;
                    end
                end
            end
            utd_pkg::MODE_UTF32LE, utd_pkg::MODE_UTF32BE: begin
                exp_next = 3'd4;
                if (mode_reg == utd_pkg::MODE_UTF32LE) begin
                    v32 = {g[7:0], g[15:8], g[23:16], g[31:24]};
                end
                if (seen_n >= 3'd4) begin
                    if (v32 >= utd_pkg::CP_LIMIT
                        || (v32 >= {16'd0, utd_pkg::SURR_HI_LO}
                            && v32 < {16'd0, utd_pkg::SURR_END})) begin
                        err = 1'b1;
                    end else begin
                        done = 1'b1;
                        cp   = v32[utd_pkg::CP_W-1:0];
                    end
                end
            end
            utd_pkg::MODE_ASCII: begin
                if (b[7]) begin
                    err = 1'b1;
                end else begin
                    done = 1'b1;
                    cp   = {13'd0, b};
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
        // Last byte with a character still open is a truncation error
        if (!done && !err && s_axis_tlast) begin
            err = 1'b1;
        end
    end

    assign emit = accept && !err_lat_reg && (done || err);

    // Next decode state
    always_comb begin
        seen_next    = seen_reg;
        gath_next    = gath_reg;
        err_lat_next = err_lat_reg;
        if (!err_lat_reg) begin
            if (done || err) begin
                seen_next = '0;
                gath_next = '0;
                if (err) begin
                    err_lat_next = 1'b1;
                end
            end else begin
                seen_next = seen_n;
                gath_next = g[utd_pkg::GATH_W-1:0];
            end
        end
        if (s_axis_tlast) begin
            seen_next    = '0;
            gath_next    = '0;
            err_lat_next = 1'b0;
        end
    end

    // Hold mode and decode state; a config write restarts at a character boundary
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= utd_pkg::MODE_UTF8;
            seen_reg    <= '0;
            exp_reg     <= '0;
            gath_reg    <= '0;
            err_lat_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg    <= cfg_wr_data;
            seen_reg    <= '0;
            exp_reg     <= '0;
            gath_reg    <= '0;
            err_lat_reg <= 1'b0;
        end else if (accept) begin
            seen_reg    <= seen_next;
            gath_reg    <= gath_next;
            err_lat_reg <= err_lat_next;
            if (err_lat_reg || done || err || s_axis_tlast) begin
                exp_reg <= '0;
            end else begin
                exp_reg <= exp_next;
            end
        end
    end

    // Output valid: load on a result, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            out_valid_reg <= emit;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_cp_reg   <= err ? '0 : cp;
            out_stat_reg <= err ? utd_pkg::STAT_ERR : utd_pkg::STAT_OK;
            out_used_reg <= seen_n;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_used_reg, out_cp_reg};
    assign m_axis_tuser  = out_stat_reg;

endmodule

### hdl/utd_checker.sv
// Port-level checker for the Unicode text decoder, bound to its top level.
// Depends on utd_pkg for field widths and status codes.
module utd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Input side is open whenever no result waits
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Error results carry a zero code point
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == utd_pkg::STAT_ERR
            |-> m_axis_tdata[utd_pkg::CP_W-1:0] == '0)
        else $error("error result with nonzero code point");

    // Byte count of a result is one to four
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[utd_pkg::OUT_W-1:utd_pkg::CP_W] != 3'd0
            && m_axis_tdata[utd_pkg::OUT_W-1:utd_pkg::CP_W] <= 3'd4)
        else $error("bytes_used out of range");

endmodule

bind unicode_text_decoder utd_checker u_utd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
